// ===== rtl/lhrp_pkg.sv =====
package lhrp_pkg;

  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_STEP_0P2 = 64'sd214748365;
  localparam int     GAIN_W      = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int     DIST_FRAC   = 8;
  localparam int     STEP_W      = 5;
  localparam int     MAX_STEPS   = 32;
  localparam longint NO_HIT_RESET = 64'sd999900;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_HIT_DISTANCE = 1'd1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD1,
    OP_LD2,
    OP_LD3,
    OP_WRAP,
    OP_FOLD,
    OP_GLO,
    OP_GHI,
    OP_GRND,
    OP_ITER
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_GLO,
    ST_GHI,
    ST_GRND,
    ST_ITER,
    ST_LOAD,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic              comp;
    logic [STEP_W-1:0] step;
  } cmd_t;

  function automatic logic [30:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524288;
      5'd12: r = 31'd262144;
      5'd13: r = 31'd131072;
      5'd14: r = 31'd65536;
      5'd15: r = 31'd32768;
      5'd16: r = 31'd16384;
      5'd17: r = 31'd8192;
      5'd18: r = 31'd4096;
      5'd19: r = 31'd2048;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd512;
      5'd22: r = 31'd256;
      5'd23: r = 31'd128;
      5'd24: r = 31'd64;
      5'd25: r = 31'd32;
      5'd26: r = 31'd16;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      5'd30: r = 31'd1;
      5'd31: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/lhrp_in_if.sv =====
interface lhrp_in_if #(
  parameter int DIST_BITS = 20
) ();
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   horizontal_angle;
  logic signed [15:0]   vertical_angle;
  logic [DIST_BITS-1:0] distance;
  logic                 end_of_scan;

  modport source (
    output valid, horizontal_angle, vertical_angle, distance, end_of_scan,
    input  ready
  );
  modport sink (
    input  valid, horizontal_angle, vertical_angle, distance, end_of_scan,
    output ready
  );
endinterface

// ===== rtl/lhrp_out_if.sv =====
interface lhrp_out_if #(
  parameter int DIST_BITS = 20
) ();
  logic                      valid;
  logic                      ready;
  logic signed [DIST_BITS:0] point_x;
  logic signed [DIST_BITS:0] point_y;
  logic signed [DIST_BITS:0] point_z;
  logic                      point_valid;
  logic                      scan_last;

  modport source (
    output valid, point_x, point_y, point_z, point_valid, scan_last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, point_valid, scan_last,
    output ready
  );
endinterface

// ===== rtl/lhrp_cfg_if.sv =====
interface lhrp_cfg_if #(
  parameter int DATA_W = 20
) ();
  logic                           valid;
  logic                           ready;
  logic [lhrp_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/lhrp_cordic.sv =====
module lhrp_cordic #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int DIST_BITS       = 20,
  parameter int V_W             = 31,
  parameter int A_W             = 35
) (
  input  logic                          clk_i,
  input  lhrp_pkg::cmd_t                cmd_i,
  input  logic [DIST_BITS-1:0]          dist_i,
  input  logic signed [15:0]            vert_i,
  input  logic signed [15:0]            horz_i,
  input  logic [ANGLE_FRAC_BITS+1:0]    scan_i,
  output logic                          in_range_o,
  output logic signed [V_W-1:0]         px_o,
  output logic signed [V_W-1:0]         py_o,
  output logic signed [V_W-1:0]         pz_o
);
  import lhrp_pkg::*;

  localparam int SH     = 30 - ANGLE_FRAC_BITS;
  localparam int MOP_W  = (V_W > 30) ? V_W - 15 : 15;
  localparam int PROD_W = MOP_W + GAIN_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic signed [A_W-1:0] PI_A      = A_W'(Q30_PI);
  localparam logic signed [A_W-1:0] HALF_PI_A = A_W'(Q30_HALF_PI);
  localparam logic signed [A_W-1:0] TWO_PI_A  = A_W'(2 * Q30_PI);

  logic signed [V_W-1:0] x_q, y_q, z_q;
  logic signed [A_W-1:0] ang_q;
  logic [ACC_W-1:0]      acc_q;

  logic signed [A_W-1:0] vert_a, horz_a, scan_a;
  logic signed [V_W-1:0] dist_v;
  logic signed [V_W-1:0] v_sel, gain_res, dx, dy;
  logic                  neg;
  logic [V_W-1:0]        mag;
  logic [MOP_W+14:0]     mag_ext;
  logic [MOP_W-1:0]      mul_a;
  logic [PROD_W-1:0]     prod;
  logic [ACC_W-1:0]      rnd;
  logic [V_W-1:0]        r_mag;
  logic signed [A_W-1:0] at;
  logic                  ang_pos;

  assign vert_a = A_W'(vert_i) <<< SH;
  assign horz_a = A_W'(horz_i) <<< SH;
  assign scan_a = A_W'(scan_i) <<< SH;
  assign dist_v = V_W'(dist_i) <<< DIST_FRAC;

  assign in_range_o = (ang_q <= PI_A) && (ang_q > -PI_A);

  assign v_sel   = cmd_i.comp ? y_q : x_q;
  assign neg     = v_sel[V_W-1];
  assign mag     = neg ? -v_sel : v_sel;
  assign mag_ext = (MOP_W+15)'(mag);
  assign mul_a   = (cmd_i.op == OP_GHI) ? mag_ext[MOP_W+14:15] : MOP_W'(mag_ext[14:0]);
  assign prod    = PROD_W'(mul_a) * PROD_W'(GAIN_Q30);
  assign rnd     = (acc_q + ACC_W'(1 << 14)) >> 15;
  assign r_mag   = V_W'(rnd);
  assign gain_res = neg ? -$signed(r_mag) : $signed(r_mag);

  assign dx      = y_q >>> cmd_i.step;
  assign dy      = x_q >>> cmd_i.step;
  assign at      = A_W'(atan_q30(cmd_i.step));
  assign ang_pos = !ang_q[A_W-1];

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LD1: begin
        x_q   <= dist_v;
        y_q   <= '0;
        ang_q <= vert_a;
      end
      OP_LD2: begin
        z_q   <= y_q;
        y_q   <= '0;
        ang_q <= horz_a;
      end
      OP_LD3: begin
        z_q   <= x_q;
        x_q   <= y_q;
        y_q   <= z_q;
        ang_q <= scan_a;
      end
      OP_WRAP: begin
        if (ang_q > PI_A) begin
          ang_q <= ang_q - TWO_PI_A;
        end else begin
          ang_q <= ang_q + TWO_PI_A;
        end
      end
      OP_FOLD: begin
        if (ang_q > HALF_PI_A) begin
          x_q   <= -x_q;
          y_q   <= -y_q;
          ang_q <= ang_q - PI_A;
        end else if (ang_q < -HALF_PI_A) begin
          x_q   <= -x_q;
          y_q   <= -y_q;
          ang_q <= ang_q + PI_A;
        end
      end
      OP_GLO: begin
        acc_q <= ACC_W'(prod >> 15);
      end
      OP_GHI: begin
        acc_q <= ACC_W'(prod) + acc_q;
      end
      OP_GRND: begin
        if (cmd_i.comp) begin
          y_q <= gain_res;
        end else begin
          x_q <= gain_res;
        end
      end
      OP_ITER: begin
        if (ang_pos) begin
          x_q   <= x_q - dx;
          y_q   <= y_q + dy;
          ang_q <= ang_q - at;
        end else begin
          x_q   <= x_q + dx;
          y_q   <= y_q - dy;
          ang_q <= ang_q + at;
        end
      end
      default: begin
      end
    endcase
  end

  assign px_o = z_q;
  assign py_o = x_q;
  assign pz_o = y_q;

endmodule

// ===== rtl/lhrp_seq.sv =====
module lhrp_seq #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           start_hit_i,
  input  logic           in_range_i,
  input  logic           out_free_i,
  output lhrp_pkg::cmd_t cmd_o,
  output logic           idle_o,
  output logic           done_o
);
  import lhrp_pkg::*;

  localparam int ITERS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITERS - 1);
  localparam logic [1:0] PASS_ELEV = 2'd0;
  localparam logic [1:0] PASS_AZIM = 2'd1;
  localparam logic [1:0] PASS_SCAN = 2'd2;

  state_e            state_q, state_d;
  logic [1:0]        pass_q, pass_d;
  logic              comp_q, comp_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= PASS_ELEV;
      comp_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      comp_q  <= comp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    comp_d     = comp_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    cmd_o.comp = comp_q;
    cmd_o.step = cnt_q;
    done_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (start_hit_i) begin
            pass_d   = PASS_ELEV;
            state_d  = ST_LOAD;
          end else begin
            state_d  = ST_DONE;
          end
        end
      end
      ST_WRAP: begin
        if (in_range_i) begin
          cmd_o.op = OP_FOLD;
          comp_d   = 1'b0;
          state_d  = ST_GLO;
        end else begin
          cmd_o.op = OP_WRAP;
        end
      end
      ST_GLO: begin
        cmd_o.op = OP_GLO;
        state_d  = ST_GHI;
      end
      ST_GHI: begin
        cmd_o.op = OP_GHI;
        state_d  = ST_GRND;
      end
      ST_GRND: begin
        cmd_o.op = OP_GRND;
        if (comp_q) begin
          cnt_d   = '0;
          state_d = ST_ITER;
        end else begin
          comp_d  = 1'b1;
          state_d = ST_GLO;
        end
      end
      ST_ITER: begin
        cmd_o.op = OP_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          if (pass_q == PASS_SCAN) begin
            state_d = ST_DONE;
          end else begin
            pass_d  = pass_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        unique case (pass_q)
          PASS_ELEV: cmd_o.op = OP_LD1;
          PASS_AZIM: cmd_o.op = OP_LD2;
          default:   cmd_o.op = OP_LD3;
        endcase
        state_d  = ST_WRAP;
      end
      ST_DONE: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/lidar_hit_to_rotated_point.sv =====
// Turns one lidar return (azimuth, elevation, distance) into a Cartesian point in millimetres,
// rotated about the x axis by the current scan angle, with outputs rounded and saturated.
// One return is worked at a time by a single shared CORDIC datapath run in three passes
// (elevation, azimuth, scan angle); the datapath's iterations set the rate. Each pass loads its
// vector, brings its angle into (-pi, pi] by whole turns, folds it, scales both components by
// the CORDIC gain and runs the iterations; a miss skips the passes and goes straight to the
// result. The input is not ready while a return is being worked. The finished point
// sits in an output register, so the next return is accepted while it waits to be taken.
// A return with end_of_scan advances the scan angle by rotation_step when its point is
// registered. Configuration writes are always accepted and must be issued while idle.
module lidar_hit_to_rotated_point #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int DIST_BITS       = 20,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhrp_cfg_if.sink   cfg_i,
  lhrp_in_if.sink    hit_i,
  lhrp_out_if.source point_o
);
  import lhrp_pkg::*;

  localparam int ANG_W = ANGLE_FRAC_BITS + 2;
  localparam int V_W   = DIST_BITS + DIST_FRAC + 3;
  localparam int A_W   = (47 - ANGLE_FRAC_BITS > 35) ? 47 - ANGLE_FRAC_BITS : 35;
  localparam int SH    = 30 - ANGLE_FRAC_BITS;
  localparam logic [ANG_W:0] PI_ANG =
    (ANG_W+1)'((Q30_PI + (64'sd1 <<< (SH - 1))) >>> SH);
  localparam logic [ANG_W-1:0] STEP_RESET =
    ANG_W'((Q30_STEP_0P2 + (64'sd1 <<< (SH - 1))) >>> SH);
  localparam logic [DIST_BITS-1:0] NO_HIT_RST = DIST_BITS'(NO_HIT_RESET);
  localparam logic signed [V_W-8:0] OUT_MAX = (V_W-7)'((64'sd1 <<< DIST_BITS) - 1);

  function automatic logic signed [DIST_BITS:0] to_mm(input logic signed [V_W-1:0] v);
    logic signed [V_W:0]   s;
    logic signed [V_W-8:0] r;
    s = (V_W+1)'(v) + (V_W+1)'(1 << (DIST_FRAC - 1));
    r = (V_W-7)'(s >>> DIST_FRAC);
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < -OUT_MAX) begin
      r = -OUT_MAX;
    end
    return (DIST_BITS+1)'(r);
  endfunction

  logic [ANG_W-1:0]     step_q;
  logic [DIST_BITS-1:0] no_hit_q;
  logic [ANG_W-1:0]     scan_angle_q, scan_angle_d;
  logic [ANG_W:0]       scan_sum;

  logic signed [15:0]   horz_q, vert_q;
  logic [DIST_BITS-1:0] dist_q;
  logic                 eos_q, hit_q;

  logic                      out_valid_q;
  logic signed [DIST_BITS:0] px_q, py_q, pz_q;
  logic                      pvalid_q, plast_q;

  logic                  hit_acc, out_free, out_load, idle, done, in_range;
  cmd_t                  cmd;
  logic signed [V_W-1:0] px, py, pz;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RESET;
      no_hit_q <= NO_HIT_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ROTATION_STEP:   step_q   <= cfg_i.data[ANG_W-1:0];
        REG_NO_HIT_DISTANCE: no_hit_q <= cfg_i.data[DIST_BITS-1:0];
      endcase
    end
  end

  assign hit_i.ready = idle;
  assign hit_acc     = hit_i.valid && idle;
  assign out_free    = !out_valid_q || point_o.ready;
  assign out_load    = done && out_free;

  always_ff @(posedge clk_i) begin
    if (hit_acc) begin
      horz_q <= hit_i.horizontal_angle;
      vert_q <= hit_i.vertical_angle;
      dist_q <= hit_i.distance;
      eos_q  <= hit_i.end_of_scan;
      hit_q  <= hit_i.distance < no_hit_q;
    end
  end

  lhrp_seq #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hit_acc),
    .start_hit_i (hit_i.distance < no_hit_q),
    .in_range_i  (in_range),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .idle_o      (idle),
    .done_o      (done)
  );

  lhrp_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .DIST_BITS       (DIST_BITS),
    .V_W             (V_W),
    .A_W             (A_W)
  ) u_cordic (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .dist_i     (dist_q),
    .vert_i     (vert_q),
    .horz_i     (horz_q),
    .scan_i     (scan_angle_q),
    .in_range_o (in_range),
    .px_o       (px),
    .py_o       (py),
    .pz_o       (pz)
  );

  always_comb begin
    scan_sum = (ANG_W+1)'(scan_angle_q) + (ANG_W+1)'(step_q);
    if (scan_sum >= PI_ANG) begin
      scan_sum = scan_sum - PI_ANG;
    end
    scan_angle_d = scan_sum[ANG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_angle_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_load && eos_q) begin
        scan_angle_q <= scan_angle_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      px_q     <= hit_q ? to_mm(px) : '0;
      py_q     <= hit_q ? to_mm(py) : '0;
      pz_q     <= hit_q ? to_mm(pz) : '0;
      pvalid_q <= hit_q;
      plast_q  <= eos_q;
    end
  end

  assign point_o.valid       = out_valid_q;
  assign point_o.point_x     = px_q;
  assign point_o.point_y     = py_q;
  assign point_o.point_z     = pz_q;
  assign point_o.point_valid = pvalid_q;
  assign point_o.scan_last   = plast_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_acc |=> !hit_i.ready)
    else $error("input ready while a return is in work");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_o.valid && !point_o.point_valid |->
      point_o.point_x == '0 && point_o.point_y == '0 && point_o.point_z == '0)
    else $error("miss result carries a nonzero point");

  a_scan_angle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_load |=> $stable(scan_angle_q))
    else $error("scan angle moved without a registered result");

endmodule

// ===== sim/lidar_hit_to_rotated_point_tb.sv =====
`timescale 1ns / 1ps

module lidar_hit_to_rotated_point_tb;

  localparam int DIST_BITS = 20;
  localparam int STEPS     = 16;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_C      = 64'sd652032874;
  localparam longint OUT_MAX     = 64'sd1048575;
  localparam int     PI_STEP     = int'((PI_Q30 + 64'sd65536) >>> 17);
  localparam logic [14:0] STEP_RESET  = 15'd1638;
  localparam logic [19:0] MISS_RESET  = 20'd999900;
  localparam logic [19:0] DIST_MAX    = 20'hFFFFF;

  typedef struct packed {
    logic signed [15:0] h;
    logic signed [15:0] v;
    logic [19:0]        d;
    logic               eos;
  } ray_t;

  typedef struct packed {
    logic signed [DIST_BITS:0] x;
    logic signed [DIST_BITS:0] y;
    logic signed [DIST_BITS:0] z;
    logic                      hit;
    logic                      last;
  } point_t;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
  } vec_t;

  logic clk_i;
  logic rst_ni;

  lhrp_cfg_if #(.DATA_W(20))        cfg_bus ();
  lhrp_in_if  #(.DIST_BITS(DIST_BITS)) ray_bus ();
  lhrp_out_if #(.DIST_BITS(DIST_BITS)) pt_bus ();

  lidar_hit_to_rotated_point dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .hit_i   (ray_bus),
    .point_o (pt_bus)
  );

  ray_t   pending_returns[$];
  point_t expected_points[$];
  int     rays_queued;
  int     rays_taken;
  int     errors;

  logic [14:0] ang_now;
  logic [14:0] step_cfg;
  logic [19:0] miss_cfg;

  bit ray_fire, cfg_fire, pt_took;
  bit ray_calm, pt_calm, pt_armed;
  int ray_gap, pt_stall;

  function automatic longint atan_entry(int i);
    case (i)
      0:  return 64'sd843314857;
      1:  return 64'sd497837829;
      2:  return 64'sd263043837;
      3:  return 64'sd133525159;
      4:  return 64'sd67021687;
      5:  return 64'sd33543516;
      6:  return 64'sd16775851;
      7:  return 64'sd8388437;
      8:  return 64'sd4194283;
      9:  return 64'sd2097149;
      30: return 64'sd1;
      31: return 64'sd1;
      default: return 64'sd1 <<< (30 - i);
    endcase
  endfunction

  function automatic longint gain_scale(longint v);
    longint mag, hi, lo, p, r;
    mag = (v < 0) ? -v : v;
    hi  = mag >>> 15;
    lo  = mag & 64'sh7FFF;
    p   = hi * GAIN_C + ((lo * GAIN_C) >>> 15);
    r   = (p + 64'sd16384) >>> 15;
    return (v < 0) ? -r : r;
  endfunction

  function automatic vec_t cordic_rot(longint xi, longint yi, longint ang);
    longint x, y, a, dx, dy;
    vec_t   res;
    int     i;
    x = xi;
    y = yi;
    a = ang;
    while (a > PI_Q30) a -= 2 * PI_Q30;
    while (a <= -PI_Q30) a += 2 * PI_Q30;
    if (a > HALF_PI_Q30) begin
      x = -x;
      y = -y;
      a -= PI_Q30;
    end else if (a < -HALF_PI_Q30) begin
      x = -x;
      y = -y;
      a += PI_Q30;
    end
    x = gain_scale(x);
    y = gain_scale(y);
    for (i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx;
        y += dy;
        a -= atan_entry(i);
      end else begin
        x += dx;
        y -= dy;
        a += atan_entry(i);
      end
    end
    res.x = x;
    res.y = y;
    return res;
  endfunction

  function automatic logic [DIST_BITS:0] to_mm(longint v);
    longint r;
    r = (v + 64'sd128) >>> 8;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < -OUT_MAX) r = -OUT_MAX;
    return 21'(r);
  endfunction

  // model the expected point of a return, and advance the scan angle after the last ray of a scan
  function automatic point_t project_return(ray_t r);
    point_t p;
    vec_t   el, az, rot;
    int     nxt;
    p = '0;
    if (r.d < miss_cfg) begin
      el  = cordic_rot(longint'(r.d) * 64'sd256, 64'sd0, longint'($signed(r.v)) * 64'sd131072);
      az  = cordic_rot(el.x, 64'sd0, longint'($signed(r.h)) * 64'sd131072);
      rot = cordic_rot(az.y, el.y, longint'(ang_now) * 64'sd131072);
      p.x   = to_mm(az.x);
      p.y   = to_mm(rot.x);
      p.z   = to_mm(rot.y);
      p.hit = 1'b1;
    end
    p.last = r.eos;
    if (r.eos) begin
      nxt = int'(ang_now) + int'(step_cfg);
      if (nxt >= PI_STEP) nxt -= PI_STEP;
      ang_now = 15'(nxt);
    end
    return p;
  endfunction

  function automatic logic signed [15:0] pick_angle();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic ray_t rand_return(logic [19:0] thr);
    ray_t r;
    int   t;
    r.h   = pick_angle();
    r.v   = pick_angle();
    r.eos = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      5, 6: r.d = 20'($urandom_range(0, 4095));
      7: begin
        t = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > int'(DIST_MAX)) t = int'(DIST_MAX);
        r.d = 20'(t);
      end
      8: r.d = $urandom_range(0, 1) ? DIST_MAX : 20'd0;
      9: r.d = 20'($urandom_range(900000, 1048575));
      default: r.d = 20'($urandom_range(0, 1048575));
    endcase
    return r;
  endfunction

  task automatic queue_return(logic signed [15:0] h, logic signed [15:0] v,
                              logic [19:0] d, logic eos);
    ray_t r;
    r.h   = h;
    r.v   = v;
    r.d   = d;
    r.eos = eos;
    pending_returns = {pending_returns, r};
    rays_queued++;
  endtask

  task automatic queue_random(int n, logic [19:0] thr);
    ray_t r;
    repeat (n) begin
      r = rand_return(thr);
      pending_returns = {pending_returns, r};
      rays_queued++;
    end
  endtask

  task automatic settle();
    while (rays_taken != rays_queued || expected_points.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_register(logic [lhrp_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // drive returns, holding each beat until taken
  always @(negedge clk_i) begin
    ray_t nxt;
    if (!rst_ni) begin
      ray_bus.valid <= 1'b0;
      ray_gap = 0;
    end else if (!ray_bus.valid || ray_fire) begin
      if (ray_gap != 0) begin
        ray_bus.valid <= 1'b0;
        ray_gap--;
      end else if (pending_returns.size() != 0) begin
        nxt = pending_returns.pop_front();
        ray_bus.valid            <= 1'b1;
        ray_bus.horizontal_angle <= nxt.h;
        ray_bus.vertical_angle   <= nxt.v;
        ray_bus.distance         <= nxt.d;
        ray_bus.end_of_scan      <= nxt.eos;
        if ($urandom_range(0, 11) == 0) ray_calm = !ray_calm;
        ray_gap = ray_calm ? 0 : $urandom_range(0, 6);
      end else begin
        ray_bus.valid <= 1'b0;
      end
    end
  end

  // hold off the point side for a random stall, drawn once per offered beat
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pt_bus.ready <= 1'b0;
      pt_armed = 1'b0;
      pt_stall = 0;
    end else begin
      if (pt_took) pt_armed = 1'b0;
      if (pt_bus.valid && !pt_armed) begin
        if ($urandom_range(0, 11) == 0) pt_calm = !pt_calm;
        pt_stall = pt_calm ? 0 : $urandom_range(0, 6);
        pt_armed = 1'b1;
      end
      if (pt_stall != 0) begin
        pt_bus.ready <= 1'b0;
        pt_stall--;
      end else begin
        pt_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    ray_t   r;
    point_t got, want;
    if (!rst_ni) begin
      ang_now  = '0;
      step_cfg = STEP_RESET;
      miss_cfg = MISS_RESET;
      ray_fire = 1'b0;
      cfg_fire = 1'b0;
      pt_took  = 1'b0;
    end else begin
      ray_fire = ray_bus.valid && ray_bus.ready;
      cfg_fire = cfg_bus.valid && cfg_bus.ready;
      pt_took  = pt_bus.valid && pt_bus.ready;
      if (cfg_fire) begin
        case (cfg_bus.index)
          lhrp_pkg::REG_ROTATION_STEP:   step_cfg = cfg_bus.data[14:0];
          lhrp_pkg::REG_NO_HIT_DISTANCE: miss_cfg = cfg_bus.data;
          default: ;
        endcase
      end
      if (ray_fire) begin
        r.h   = ray_bus.horizontal_angle;
        r.v   = ray_bus.vertical_angle;
        r.d   = ray_bus.distance;
        r.eos = ray_bus.end_of_scan;
        want  = project_return(r);
        expected_points = {expected_points, want};
        rays_taken++;
      end
      if (pt_took) begin
        got.x    = pt_bus.point_x;
        got.y    = pt_bus.point_y;
        got.z    = pt_bus.point_z;
        got.hit  = pt_bus.point_valid;
        got.last = pt_bus.scan_last;
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: point with nothing pending: x=%0d y=%0d z=%0d valid=%0b last=%0b",
                     $realtime, $signed(got.x), $signed(got.y), $signed(got.z),
                     got.hit, got.last);
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.hit !== want.hit || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: point mismatch exp x=%0d y=%0d z=%0d valid=%0b last=%0b got x=%0d y=%0d z=%0d valid=%0b last=%0b",
                       $realtime, $signed(want.x), $signed(want.y), $signed(want.z),
                       want.hit, want.last, $signed(got.x), $signed(got.y),
                       $signed(got.z), got.hit, got.last);
          end
        end
      end
    end
  end

  initial begin
    rays_queued = 0;
    rays_taken  = 0;
    errors      = 0;
    ray_calm    = 1'b0;
    pt_calm     = 1'b0;
    rst_ni                   = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = lhrp_pkg::REG_ROTATION_STEP;
    cfg_bus.data             = '0;
    ray_bus.valid            = 1'b0;
    ray_bus.horizontal_angle = '0;
    ray_bus.vertical_angle   = '0;
    ray_bus.distance         = '0;
    ray_bus.end_of_scan      = 1'b0;
    pt_bus.ready             = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    queue_return(16'sd0, 16'sd0, 20'd1000, 1'b0);
    queue_return(16'sd25736, 16'sd0, 20'd5000, 1'b0);
    queue_return(-16'sd25736, 16'sd0, 20'd5000, 1'b0);
    queue_return(16'sd0, 16'sd25736, 20'd7000, 1'b0);
    queue_return(16'sd0, -16'sd25736, 20'd7000, 1'b0);
    queue_return(16'sd32767, -16'sd32768, 20'd100000, 1'b0);
    queue_return(-16'sd32768, 16'sd32767, 20'd100000, 1'b1);
    queue_return(16'sd12868, 16'sd6434, 20'd0, 1'b0);
    queue_return(-16'sd12868, -16'sd6434, 20'd999899, 1'b1);
    queue_return(16'sd3000, 16'sd3000, 20'd999900, 1'b0);
    queue_return(16'sd3000, 16'sd3000, DIST_MAX, 1'b1);
    queue_return(16'sd6000, -16'sd4000, 20'd700000, 1'b1);
    queue_return(-16'sd6000, 16'sd4000, 20'd700000, 1'b0);
    settle();

    set_register(lhrp_pkg::REG_ROTATION_STEP, 20'd25735);
    set_register(lhrp_pkg::REG_NO_HIT_DISTANCE, DIST_MAX);
    queue_return(16'sd0, 16'sd0, 20'd1048574, 1'b0);
    queue_return(-16'sd25736, 16'sd0, 20'd1048574, 1'b0);
    queue_return(16'sd0, 16'sd12868, 20'd1048574, 1'b1);
    queue_return(16'sd0, 16'sd0, DIST_MAX, 1'b1);
    queue_return(16'sd0, 16'sd6434, 20'd1048574, 1'b1);
    queue_random(100, DIST_MAX);
    settle();

    set_register(lhrp_pkg::REG_ROTATION_STEP, 20'd0);
    set_register(lhrp_pkg::REG_NO_HIT_DISTANCE, 20'd0);
    queue_random(30, 20'd0);
    settle();

    set_register(lhrp_pkg::REG_ROTATION_STEP, 20'h7FFF);
    set_register(lhrp_pkg::REG_NO_HIT_DISTANCE, 20'd600000);
    queue_random(110, 20'd600000);
    settle();

    set_register(lhrp_pkg::REG_ROTATION_STEP, 20'($urandom_range(0, 25735)));
    set_register(lhrp_pkg::REG_NO_HIT_DISTANCE, 20'($urandom_range(0, 1048575)));
    queue_random(100, 20'd500000);
    settle();

    set_register(lhrp_pkg::REG_ROTATION_STEP, 20'd1);
    set_register(lhrp_pkg::REG_NO_HIT_DISTANCE, 20'(MISS_RESET));
    queue_random(100, MISS_RESET);
    settle();

    repeat (100) @(negedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("lidar_hit_to_rotated_point_tb: clean");
    end else begin
      $display("lidar_hit_to_rotated_point_tb: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("lidar_hit_to_rotated_point_tb: errors");
    $finish;
  end

endmodule
